// ===== rtl/i2a_pkg.sv =====
// Shared types, constants and the weight table for the integer-to-decimal text block.
// Used by the cell, the character emitter, the top level and the checker.
package i2a_pkg;

  localparam int NUM_DIGITS     = 10;
  localparam int BITS_PER_DIGIT = 4;
  localparam int NUM_CELLS      = NUM_DIGITS * BITS_PER_DIGIT;
  localparam int MAX_CHARS      = NUM_DIGITS + 1;
  localparam int VALUE_W        = 32;
  localparam int WEIGHT_W       = 34;
  localparam int QUO_W          = NUM_CELLS;
  localparam int CHAR_W         = 6;
  localparam int DIG_IDX_W      = $clog2(NUM_DIGITS);
  localparam int CELL_IDX_W     = $clog2(NUM_CELLS);
  localparam int SLOT_W         = $clog2(MAX_CHARS);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

  // One beat of work travelling down the chain
  typedef struct packed {
    logic               valid;
    logic               neg;
    logic [VALUE_W-1:0] rem;
    logic [QUO_W-1:0]   quo;
  } stage_t;

  typedef logic [BITS_PER_DIGIT-1:0] digit_t;

  // Power of ten for a digit position, most significant first
  function automatic logic [WEIGHT_W-1:0] pow10(input logic [DIG_IDX_W-1:0] d);
    logic [WEIGHT_W-1:0] p;
    unique case (d)
      4'd0:    p = 34'd1000000000;
      4'd1:    p = 34'd100000000;
      4'd2:    p = 34'd10000000;
      4'd3:    p = 34'd1000000;
      4'd4:    p = 34'd100000;
      4'd5:    p = 34'd10000;
      4'd6:    p = 34'd1000;
      4'd7:    p = 34'd100;
      4'd8:    p = 34'd10;
      4'd9:    p = 34'd1;
      default: p = 34'd1;
    endcase
    return p;
  endfunction

  // Trial weight of a cell: power of ten times 8, 4, 2 or 1
  function automatic logic [WEIGHT_W-1:0] cell_weight(input logic [CELL_IDX_W-1:0] idx);
    logic [DIG_IDX_W-1:0] d;
    logic [1:0]           b;
    d = DIG_IDX_W'(idx >> 2);
    b = 2'd3 - idx[1:0];
    return pow10(d) << b;
  endfunction

endpackage

// ===== rtl/i2a_cell.sv =====
// One restoring-division step: trial-subtract a fixed weight, shift in the quotient bit.
// Depends on i2a_pkg for the beat type and widths.
module i2a_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  i2a_pkg::stage_t               cell_i,
  input  logic [i2a_pkg::WEIGHT_W-1:0]  weight_i,
  output i2a_pkg::stage_t               cell_o
);
  import i2a_pkg::*;

  stage_t stage_r;
  stage_t stage_nxt;
  logic   take;

  // Compare against the weight and subtract where it fits
  always_comb begin
    take            = {{(WEIGHT_W-VALUE_W){1'b0}}, cell_i.rem} >= weight_i;
    stage_nxt.valid = cell_i.valid;
    stage_nxt.neg   = cell_i.neg;
    stage_nxt.rem   = take ? (cell_i.rem - weight_i[VALUE_W-1:0]) : cell_i.rem;
    stage_nxt.quo   = {cell_i.quo[QUO_W-2:0], take};
  end

  // Advance the beat every cycle; drop only the valid flag under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r.valid <= stage_nxt.valid;
    end
    stage_r.neg <= stage_nxt.neg;
    stage_r.rem <= stage_nxt.rem;
    stage_r.quo <= stage_nxt.quo;
  end

  assign cell_o = stage_r;

endmodule

// ===== rtl/i2a_emit.sv =====
// Character emitter: takes the digits from the chain tail and sends sign and digits.
// Depends on i2a_pkg for the beat type, digit layout and character codes.
module i2a_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  i2a_pkg::stage_t             tail_i,
  output logic                        ch_valid_o,
  output logic [i2a_pkg::CHAR_W-1:0]  ch_char_o,
  output logic                        ch_last_o
);
  import i2a_pkg::*;

  localparam logic [DIG_IDX_W-1:0] LAST_DIG = DIG_IDX_W'(NUM_DIGITS - 1);

  logic                            act_r;
  logic                            act_nxt;
  logic                            sign_r;
  logic                            sign_nxt;
  logic [DIG_IDX_W-1:0]            idx_r;
  logic [DIG_IDX_W-1:0]            idx_nxt;
  logic [NUM_DIGITS-1:0][BITS_PER_DIGIT-1:0] dig_r;
  logic [NUM_DIGITS-1:0][BITS_PER_DIGIT-1:0] dig_in;
  logic [DIG_IDX_W-1:0]            first_dig;
  digit_t                          cur_dig;
  logic                            at_last;

  // Unpack the quotient into digits and find the leading non-zero one
  always_comb begin
    first_dig = LAST_DIG;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      dig_in[k] = tail_i.quo[QUO_W-1-k*BITS_PER_DIGIT -: BITS_PER_DIGIT];
    end
    for (int k = NUM_DIGITS - 1; k >= 0; k--) begin
      if (dig_in[k] != '0) begin
        first_dig = DIG_IDX_W'(k);
      end
    end
  end

  // Drive the current character
  always_comb begin
    cur_dig    = dig_r[idx_r];
    at_last    = !sign_r && (idx_r == LAST_DIG);
    ch_valid_o = act_r;
    ch_char_o  = sign_r ? CHAR_MINUS : (CHAR_ZERO + {{(CHAR_W-BITS_PER_DIGIT){1'b0}}, cur_dig});
    ch_last_o  = at_last;
  end

  // Load a new number or step through the current one
  always_comb begin
    act_nxt  = act_r;
    sign_nxt = sign_r;
    idx_nxt  = idx_r;
    if (act_r) begin
      if (sign_r) begin
        sign_nxt = 1'b0;
      end else if (at_last) begin
        act_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
    if (tail_i.valid) begin
      act_nxt  = 1'b1;
      sign_nxt = tail_i.neg;
      idx_nxt  = first_dig;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else begin
      act_r <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sign_r <= sign_nxt;
    idx_r  <= idx_nxt;
    if (tail_i.valid) begin
      dig_r <= dig_in;
    end
  end

endmodule

// ===== rtl/int32_to_decimal_ascii.sv =====
// Signed 32-bit integer to decimal ASCII text, one character per output beat.
// Throughput: one character per cycle, 1 to 11 per number; start is refused while busy.
// The 40-cell trial-subtraction chain sets latency; the 11-character output slot sets rate.
// Reset: synchronous, active low; empties the chain and the emitter, busy drops at once.
// The receiver cannot stall: each character strobe lasts exactly one cycle.
module int32_to_decimal_ascii (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [31:0]           in_value,
  output logic                         out_valid,
  output logic [i2a_pkg::CHAR_W-1:0]   out_ascii_char,
  output logic                         out_is_last
);
  import i2a_pkg::*;

  stage_t              chain [0:NUM_CELLS];
  logic                accept;
  logic [VALUE_W-1:0]  raw;
  logic [SLOT_W-1:0]   slot_cnt_r;
  logic [SLOT_W-1:0]   slot_cnt_nxt;

  assign accept = start && !busy;
  assign raw    = in_value;

  // Form sign and magnitude at the head of the chain
  always_comb begin
    chain[0].valid = accept;
    chain[0].neg   = raw[VALUE_W-1];
    chain[0].rem   = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
    chain[0].quo   = '0;
  end

  // Reserve one output slot, sized for the longest number, per accepted beat
  always_comb begin
    slot_cnt_nxt = slot_cnt_r;
    if (accept) begin
      slot_cnt_nxt = SLOT_W'(MAX_CHARS - 1);
    end else if (slot_cnt_r != '0) begin
      slot_cnt_nxt = slot_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_cnt_r <= '0;
    end else begin
      slot_cnt_r <= slot_cnt_nxt;
    end
  end

  assign busy = (slot_cnt_r != '0);

  // Chain of trial-subtraction cells, four per decimal digit
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    i2a_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_i   (chain[g]),
      .weight_i (cell_weight(CELL_IDX_W'(g))),
      .cell_o   (chain[g+1])
    );
  end

  i2a_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .tail_i     (chain[NUM_CELLS]),
    .ch_valid_o (out_valid),
    .ch_char_o  (out_ascii_char),
    .ch_last_o  (out_is_last)
  );

endmodule

// ===== rtl/i2a_checker.sv =====
// Port-level checker for the integer-to-decimal text block, bound to the top level.
// Depends on i2a_pkg for the character codes.
module i2a_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [i2a_pkg::CHAR_W-1:0]  out_ascii_char,
  input logic                        out_is_last
);
  import i2a_pkg::*;

  logic accept;
  assign accept = start && !busy;

  // An accepted beat holds off the next one
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after an accepted beat");

  // Characters are a minus sign or a decimal digit
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ascii_char == CHAR_MINUS ||
                   (out_ascii_char >= CHAR_ZERO && out_ascii_char <= CHAR_ZERO + 6'd9)))
    else $error("character outside sign and digit codes");

  // The sign never closes a number
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ascii_char == CHAR_MINUS) |-> !out_is_last)
    else $error("minus sign flagged as last");

  // A sign is always followed by a digit in the next cycle
  a_sign_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ascii_char == CHAR_MINUS) |=>
      (out_valid && out_ascii_char != CHAR_MINUS))
    else $error("minus sign not followed by a digit");

  // Reset empties the block
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !busy))
    else $error("output or busy active after reset");

endmodule

bind int32_to_decimal_ascii i2a_checker u_i2a_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_ascii_char (out_ascii_char),
  .out_is_last    (out_is_last)
);
